// ===== rtl/core/fcwm_pkg.sv =====
`default_nettype none

package fcwm_pkg;

    localparam int WORD_W = 32;
    localparam int ADDR_W = 7;

    // Host actions.
    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_LOAD  = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_STEP  = 3'd3;
    localparam logic [2:0] ACT_CARD  = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_WAIT = 3'd1;
    localparam logic [2:0] ST_HALT = 3'd2;
    localparam logic [2:0] ST_ADDR = 3'd3;
    localparam logic [2:0] ST_IGN  = 3'd4;

    // Run modes.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_WAIT = 2'd2;
    localparam logic [1:0] MODE_HALT = 2'd3;

    // Read address selects.
    localparam logic [1:0] RD_IC  = 2'd0;
    localparam logic [1:0] RD_LOC = 2'd1;
    localparam logic [1:0] RD_PTR = 2'd2;

    // Opcode characters.
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam logic [WORD_W-1:0] SPACES4 = 32'h2020_2020;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] data_word;
        logic              card_last;
    } t_in;

    typedef struct packed {
        logic [2:0]        status;
        logic              print_valid;
        logic [WORD_W-1:0] print_word;
        logic              line_end;
        logic [ADDR_W-1:0] counter_now;
        logic              compare_flag;
    } t_out;

    typedef struct packed {
        logic       clear;
        logic       start_run;
        logic       host_write;
        logic       card_write;
        logic       set_mode;
        logic [1:0] mode;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       fetch;
        logic       ic_to_loc;
        logic       card_setup;
        logic       store_r;
        logic       load_r;
        logic       cmp;
        logic       ptr_load;
        logic       ptr_inc;
        logic       emit;
        logic [2:0] emit_status;
        logic       emit_print;
        logic       emit_le;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       flag;
        logic       addr_ok;
        logic       card_last;
        logic       ic_oob;
        logic       op_h;
        logic       op_known;
        logic       op_g;
        logic       op_p;
        logic       op_l;
        logic       op_s;
        logic       op_c;
        logic       op_b;
        logic       opnd_ok;
        logic       print_ok;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/fcwm_datapath.sv =====
`default_nettype none

module fcwm_datapath #(
    parameter int MEMORY_WORDS = 100,
    parameter int LINE_WORDS   = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire fcwm_pkg::t_in    i_cmd,
    input  wire fcwm_pkg::t_dp_cmd i_dp_cmd,
    output fcwm_pkg::t_dp_sts     o_sts,
    output logic                  o_done,
    output fcwm_pkg::t_out        o_res
);
    import fcwm_pkg::*;

    localparam int AW = $clog2(MEMORY_WORDS);

    logic [WORD_W-1:0] mem [MEMORY_WORDS];
    logic [MEMORY_WORDS-1:0] r_valid;

    logic [WORD_W-1:0] r_rdata;
    logic              r_rvld;
    logic [WORD_W-1:0] r_r;
    logic [WORD_W-1:0] r_ir;
    logic [ADDR_W-1:0] r_ic;
    logic              r_flag;
    logic [1:0]        r_mode;
    logic [ADDR_W-1:0] r_cp;
    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_ptr;

    logic              r_done;
    logic [2:0]        r_status;
    logic              r_pv;
    logic [WORD_W-1:0] r_word;
    logic              r_le;

    logic [WORD_W-1:0] rword;
    logic [7:0]        op;
    logic [7:0]        d1;
    logic [7:0]        d2;
    logic [ADDR_W-1:0] loc;
    logic              in_window;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;

    // A word never written since the last clear reads as zero.
    assign rword = r_rvld ? r_rdata : '0;

    assign op  = r_ir[31:24];
    assign d1  = r_ir[15:8] - CH_ZERO;
    assign d2  = r_ir[7:0] - CH_ZERO;
    assign loc = {d1[3:0], 3'b000} + ADDR_W'({d1[3:0], 1'b0}) + ADDR_W'(d2[3:0]);

    assign in_window = (r_cp >= r_base) && ((r_cp - r_base) < ADDR_W'(LINE_WORDS))
                     && (r_cp < ADDR_W'(MEMORY_WORDS));

    always_comb begin
        o_sts           = '0;
        o_sts.mode      = r_mode;
        o_sts.flag      = r_flag;
        o_sts.addr_ok   = i_cmd.address < ADDR_W'(MEMORY_WORDS);
        o_sts.card_last = i_cmd.card_last;
        o_sts.ic_oob    = r_ic >= ADDR_W'(MEMORY_WORDS);
        o_sts.op_h      = op == CH_H;
        o_sts.op_g      = op == CH_G;
        o_sts.op_p      = op == CH_P;
        o_sts.op_l      = op == CH_L;
        o_sts.op_s      = op == CH_S;
        o_sts.op_c      = op == CH_C;
        o_sts.op_b      = op == CH_B;
        o_sts.op_known  = o_sts.op_g | o_sts.op_p | o_sts.op_l | o_sts.op_s
                        | o_sts.op_c | o_sts.op_b;
        o_sts.opnd_ok   = (d1 <= 8'd9) && (d2 <= 8'd9) && (loc < ADDR_W'(MEMORY_WORDS));
        o_sts.print_ok  = ({1'b0, loc} + 8'(LINE_WORDS)) <= 8'(MEMORY_WORDS);
    end

    always_comb begin
        we    = 1'b0;
        waddr = loc;
        wdata = r_r;
        if (i_dp_cmd.host_write) begin
            we    = 1'b1;
            waddr = i_cmd.address;
            wdata = i_cmd.data_word;
        end else if (i_dp_cmd.card_write) begin
            we    = in_window;
            waddr = r_cp;
            wdata = i_cmd.data_word;
        end else if (i_dp_cmd.store_r) begin
            we    = 1'b1;
        end
    end

    always_comb begin
        unique case (i_dp_cmd.rd_sel)
            RD_IC:   raddr = r_ic;
            RD_LOC:  raddr = loc;
            RD_PTR:  raddr = r_ptr;
            default: raddr = r_ic;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr[AW-1:0]] <= wdata;
        end
        if (i_dp_cmd.rd_en) begin
            r_rdata <= mem[raddr[AW-1:0]];
            r_rvld  <= r_valid[raddr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_dp_cmd.clear) begin
            r_valid <= '0;
            r_r     <= SPACES4;
            r_ir    <= SPACES4;
            r_ic    <= '0;
            r_flag  <= 1'b0;
            r_mode  <= MODE_IDLE;
            r_cp    <= '0;
            r_base  <= '0;
        end else begin
            if (we) begin
                r_valid[waddr[AW-1:0]] <= 1'b1;
            end
            if (i_dp_cmd.start_run) begin
                r_ic   <= '0;
                r_cp   <= '0;
                r_mode <= MODE_RUN;
            end
            if (i_dp_cmd.set_mode) begin
                r_mode <= i_dp_cmd.mode;
            end
            if (i_dp_cmd.fetch) begin
                r_ir <= rword;
                r_ic <= r_ic + 1'b1;
            end
            if (i_dp_cmd.ic_to_loc) begin
                r_ic <= loc;
            end
            if (i_dp_cmd.card_setup) begin
                r_cp   <= loc;
                r_base <= loc;
            end
            if (i_dp_cmd.card_write && in_window) begin
                r_cp <= r_cp + 1'b1;
            end
            if (i_dp_cmd.load_r) begin
                r_r <= rword;
            end
            if (i_dp_cmd.cmp) begin
                r_flag <= rword == r_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.ptr_load) begin
            r_ptr <= loc;
        end else if (i_dp_cmd.ptr_inc) begin
            r_ptr <= r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_dp_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit) begin
            r_status <= i_dp_cmd.emit_status;
            r_pv     <= i_dp_cmd.emit_print;
            r_word   <= i_dp_cmd.emit_print ? rword : '0;
            r_le     <= i_dp_cmd.emit_le;
        end
    end

    // Counter and flag are read straight from the state registers, which
    // hold their post-item values during the result cycle.
    always_comb begin
        o_res.status       = r_status;
        o_res.print_valid  = r_pv;
        o_res.print_word   = r_word;
        o_res.line_end     = r_le;
        o_res.counter_now  = r_ic;
        o_res.compare_flag = r_flag;
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/fcwm_ctrl.sv =====
`default_nettype none

module fcwm_ctrl #(
    parameter int LINE_WORDS = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [2:0]        i_action,
    input  wire fcwm_pkg::t_dp_sts i_sts,
    output fcwm_pkg::t_dp_cmd      o_dp_cmd,
    output logic                   o_busy
);
    import fcwm_pkg::*;

    localparam int CW = $clog2(LINE_WORDS + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_FETCH     = 3'd1;
    localparam logic [2:0] S_DECODE    = 3'd2;
    localparam logic [2:0] S_LOAD      = 3'd3;
    localparam logic [2:0] S_CMP       = 3'd4;
    localparam logic [2:0] S_PRINT     = 3'd5;
    localparam logic [2:0] S_PRINT_END = 3'd6;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    t_dp_cmd       cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.emit = 1'b1;
                    unique case (i_action)
                        ACT_CLEAR: begin
                            cmd.clear       = 1'b1;
                            cmd.emit_status = ST_OK;
                        end
                        ACT_LOAD: begin
                            cmd.host_write  = i_sts.addr_ok;
                            cmd.emit_status = i_sts.addr_ok ? ST_OK : ST_ADDR;
                        end
                        ACT_START: begin
                            cmd.start_run   = 1'b1;
                            cmd.emit_status = ST_OK;
                        end
                        ACT_STEP: begin
                            priority if (i_sts.mode == MODE_RUN && i_sts.ic_oob) begin
                                cmd.set_mode    = 1'b1;
                                cmd.mode        = MODE_HALT;
                                cmd.emit_status = ST_ADDR;
                            end else if (i_sts.mode == MODE_RUN) begin
                                cmd.emit   = 1'b0;
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_IC;
                                n_state    = S_FETCH;
                            end else if (i_sts.mode == MODE_WAIT) begin
                                cmd.emit_status = ST_WAIT;
                            end else if (i_sts.mode == MODE_HALT) begin
                                cmd.emit_status = ST_HALT;
                            end else begin
                                cmd.emit_status = ST_IGN;
                            end
                        end
                        ACT_CARD: begin
                            if (i_sts.mode != MODE_WAIT) begin
                                cmd.emit_status = ST_IGN;
                            end else if (i_sts.card_last) begin
                                cmd.card_write  = 1'b1;
                                cmd.set_mode    = 1'b1;
                                cmd.mode        = MODE_RUN;
                                cmd.emit_status = ST_OK;
                            end else begin
                                cmd.card_write  = 1'b1;
                                cmd.emit_status = ST_WAIT;
                            end
                        end
                        default: begin
                            cmd.emit_status = ST_IGN;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                cmd.fetch = 1'b1;
                n_state   = S_DECODE;
            end
            S_DECODE: begin
                n_state  = S_IDLE;
                cmd.emit = 1'b1;
                priority if (i_sts.op_h) begin
                    cmd.set_mode    = 1'b1;
                    cmd.mode        = MODE_HALT;
                    cmd.emit_status = ST_HALT;
                    cmd.emit_le     = 1'b1;
                end else if ((i_sts.op_b && !i_sts.flag) || !i_sts.op_known) begin
                    cmd.emit_status = ST_OK;
                end else if (!i_sts.opnd_ok || (i_sts.op_p && !i_sts.print_ok)) begin
                    cmd.set_mode    = 1'b1;
                    cmd.mode        = MODE_HALT;
                    cmd.emit_status = ST_ADDR;
                end else if (i_sts.op_g) begin
                    cmd.card_setup  = 1'b1;
                    cmd.set_mode    = 1'b1;
                    cmd.mode        = MODE_WAIT;
                    cmd.emit_status = ST_WAIT;
                end else if (i_sts.op_p) begin
                    cmd.emit     = 1'b0;
                    cmd.ptr_load = 1'b1;
                    n_cnt        = '0;
                    n_state      = S_PRINT;
                end else if (i_sts.op_l) begin
                    cmd.emit   = 1'b0;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LOC;
                    n_state    = S_LOAD;
                end else if (i_sts.op_s) begin
                    cmd.store_r     = 1'b1;
                    cmd.emit_status = ST_OK;
                end else if (i_sts.op_c) begin
                    cmd.emit   = 1'b0;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LOC;
                    n_state    = S_CMP;
                end else begin
                    cmd.ic_to_loc   = 1'b1;
                    cmd.emit_status = ST_OK;
                end
            end
            S_LOAD: begin
                cmd.load_r      = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_OK;
                n_state         = S_IDLE;
            end
            S_CMP: begin
                cmd.cmp         = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_OK;
                n_state         = S_IDLE;
            end
            S_PRINT: begin
                // Each cycle reads the next word and sends out the one read
                // in the cycle before.
                cmd.rd_en       = 1'b1;
                cmd.rd_sel      = RD_PTR;
                cmd.ptr_inc     = 1'b1;
                cmd.emit        = r_cnt != '0;
                cmd.emit_print  = 1'b1;
                cmd.emit_status = ST_OK;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CW'(LINE_WORDS - 1)) begin
                    n_state = S_PRINT_END;
                end
            end
            S_PRINT_END: begin
                cmd.emit        = 1'b1;
                cmd.emit_print  = 1'b1;
                cmd.emit_le     = 1'b1;
                cmd.emit_status = ST_OK;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_dp_cmd = cmd;
    assign o_busy   = r_state != S_IDLE;

endmodule

`default_nettype wire

// ===== rtl/core/four_char_word_machine_executor.sv =====
`default_nettype none

// Channel    Direction  Handshake               Payload
// command    in         start high, busy low    i_cmd  (t_in)
// result     out        o_done for one cycle    o_res  (t_out)
//
// Clear, load, start, card and idle-step commands return their result on the
// following cycle. A running step holds busy through the fetch and decode states
// after its transfer, plus the load or compare state for LR and CR, and its
// result follows. A PD step reads one word per cycle through the single memory
// read port and holds busy through fetch, decode and the print states; its words
// come out one per cycle, the last in the first cycle with busy low. Reset is
// synchronous and clears memory at once through per-word valid bits. The
// receiver cannot stall; results are never held.

module four_char_word_machine_executor #(
    parameter int MEMORY_WORDS = 100,
    parameter int LINE_WORDS   = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire fcwm_pkg::t_in i_cmd,
    output logic               o_done,
    output fcwm_pkg::t_out     o_res
);
    import fcwm_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    fcwm_ctrl #(
        .LINE_WORDS(LINE_WORDS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_cmd.action),
        .i_sts    (dp_sts),
        .o_dp_cmd (dp_cmd),
        .o_busy   (busy)
    );

    fcwm_datapath #(
        .MEMORY_WORDS(MEMORY_WORDS),
        .LINE_WORDS  (LINE_WORDS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_dp_cmd (dp_cmd),
        .o_sts    (dp_sts),
        .o_done   (o_done),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire
